FILE: hdl/psbs_pkg.sv
// Shared constants for the prefix-sum bucket search block.
package psbs_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned SUM_WIDTH_DEF   = 32;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned BUCKET_W = 11;

  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

endpackage

FILE: hdl/prefix_sum_bucket_search.sv
// Prefix-sum table with a lower-bound binary search over a synchronous memory.
//
// Input: an item is taken at a rising edge with start high and busy low.
//   in_mode = append: in_value is added to the saturating running total and the
//   new total is written as the next table entry. No beat is returned, busy
//   stays low and another item may follow in the next cycle. A full table drops
//   the append and returns one beat with out_load_dropped set.
//   in_mode = query: in_value is a position. The search reads one table entry a
//   cycle from the prefix memory and narrows the range on each compare.
// Output: one beat per query or dropped append, out_valid high for one cycle.
//   The receiver cannot stall; each beat must be taken as it appears.
// Timing: a dropped append or a query on an empty table gives its beat in the
//   next cycle. A query on n entries does one memory read and compare per
//   halving of the range until the range is empty. busy is high while the
//   search runs and is low again in the cycle that the beat appears.
// Reset clears the entry count and running total; the memory is not cleared
//   and entries at or beyond the count are never used.
module prefix_sum_bucket_search
  import psbs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned SUM_WIDTH   = SUM_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_mode,
  input  logic [VALUE_W-1:0]  in_value,
  output logic                out_valid,
  output logic [BUCKET_W-1:0] out_bucket_number,
  output logic                out_not_found,
  output logic                out_load_dropped
);

  localparam int unsigned AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW    = ((SUM_WIDTH > VALUE_W) ? SUM_WIDTH : VALUE_W) + 1;
  localparam int unsigned WIDE  = ((CNT_W + 1) > BUCKET_W) ? (CNT_W + 1) : BUCKET_W;
  localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;
  localparam logic [CNT_W-1:0]     DEPTH_C = CNT_W'(TABLE_DEPTH);

  typedef enum logic {ST_IDLE, ST_SEARCH} state_t;

  state_t               state_r;
  logic                 out_valid_r;
  logic [BUCKET_W-1:0]  bucket_r;
  logic                 not_found_r;
  logic                 dropped_r;
  logic [CNT_W-1:0]     count_r;
  logic [SUM_WIDTH-1:0] total_r;
  logic [CNT_W-1:0]     lo_r;
  logic [CNT_W-1:0]     hi_r;
  logic [CNT_W-1:0]     mid_r;
  logic [VALUE_W-1:0]   pos_r;

  logic [SUM_WIDTH-1:0] mem [TABLE_DEPTH];
  logic [SUM_WIDTH-1:0] rd_data_r;

  logic                 accept;
  logic                 table_full;
  logic                 wr_en;
  logic [EW-1:0]        sum_ext;
  logic [SUM_WIDTH-1:0] total_nxt;
  logic                 cmp_ge;
  logic [CNT_W-1:0]     lo_nxt;
  logic [CNT_W-1:0]     hi_nxt;
  logic [CNT_W-1:0]     mid_nxt;
  logic [CNT_W-1:0]     rd_idx;
  logic [WIDE-1:0]      bucket_wide;

  assign busy       = (state_r == ST_SEARCH);
  assign accept     = start && !busy;
  assign table_full = (count_r == DEPTH_C);
  assign wr_en      = accept && (in_mode == MODE_APPEND) && !table_full;

  // saturating running total
  assign sum_ext   = EW'(total_r) + EW'(in_value);
  assign total_nxt = (sum_ext > EW'(SUM_MAX)) ? SUM_MAX : sum_ext[SUM_WIDTH-1:0];

  // narrow the search range on the entry read last cycle
  assign cmp_ge      = (EW'(rd_data_r) >= EW'(pos_r));
  assign lo_nxt      = cmp_ge ? lo_r : mid_r + CNT_W'(1);
  assign hi_nxt      = cmp_ge ? mid_r : hi_r;
  assign mid_nxt     = lo_nxt + ((hi_nxt - lo_nxt) >> 1);
  assign rd_idx      = (state_r == ST_SEARCH) ? mid_nxt : (count_r >> 1);
  assign bucket_wide = WIDE'(lo_nxt) + WIDE'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= total_nxt;
    end
    rd_data_r <= mem[rd_idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      total_r     <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_mode == MODE_APPEND) begin
              if (table_full) begin
                out_valid_r <= 1'b1;
                bucket_r    <= '0;
                not_found_r <= 1'b0;
                dropped_r   <= 1'b1;
              end else begin
                total_r <= total_nxt;
                count_r <= count_r + CNT_W'(1);
              end
            end else if (count_r == '0) begin
              out_valid_r <= 1'b1;
              bucket_r    <= BUCKET_W'(1);
              not_found_r <= 1'b1;
              dropped_r   <= 1'b0;
            end else begin
              pos_r   <= in_value;
              lo_r    <= '0;
              hi_r    <= count_r;
              mid_r   <= count_r >> 1;
              state_r <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          lo_r  <= lo_nxt;
          hi_r  <= hi_nxt;
          mid_r <= mid_nxt;
          if (lo_nxt >= hi_nxt) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
            dropped_r   <= 1'b0;
            if (lo_nxt >= count_r) begin
              bucket_r    <= BUCKET_W'(1);
              not_found_r <= 1'b1;
            end else begin
              bucket_r    <= bucket_wide[BUCKET_W-1:0];
              not_found_r <= 1'b0;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_bucket_number = bucket_r;
  assign out_not_found     = not_found_r;
  assign out_load_dropped  = dropped_r;

  a_range_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (lo_r < hi_r) && (hi_r <= count_r))
    else $error("search range outside stored entries");

  a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_load_dropped) |-> (count_r == DEPTH_C) && $stable(count_r))
    else $error("append dropped while table not full");

  a_count_no_change_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |=> $stable(count_r) && $stable(total_r))
    else $error("table changed during search");

  a_result_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_not_found && out_load_dropped))
    else $error("query and drop flags raised together");

endmodule

FILE: tb/tb_prefix_sum_bucket_search.sv
// Self-checking testbench for the prefix-sum bucket search block.
`timescale 1ns / 100ps

module tb_prefix_sum_bucket_search
  import psbs_pkg::*;
();

  localparam int unsigned DEPTH         = TABLE_DEPTH_DEF;
  localparam int unsigned RANDOM_ITEMS  = 1700;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam logic [VALUE_W-1:0] SUM_MAX = '1;

  typedef struct packed {
    logic [BUCKET_W-1:0] bucket;
    logic                not_found;
    logic                load_dropped;
  } answer_t;

  class bucket_answer_board;
    logic [VALUE_W-1:0] prefix_totals [DEPTH];
    int unsigned        entry_count = 0;
    logic [VALUE_W-1:0] running_total = '0;
    int unsigned        errors = 0;
    answer_t            pending_answers [$];

    function void note_item(logic mode, logic [VALUE_W-1:0] value);
      logic [VALUE_W:0] sum;
      int unsigned      lo;
      int unsigned      hi;
      int unsigned      mid;
      answer_t          ans;
      if (mode == MODE_APPEND) begin
        if (entry_count >= DEPTH) begin
          ans = '{bucket: '0, not_found: 1'b0, load_dropped: 1'b1};
          pending_answers = {pending_answers, ans};
        end else begin
          sum = {1'b0, running_total} + {1'b0, value};
          running_total = sum[VALUE_W] ? SUM_MAX : sum[VALUE_W-1:0];
          prefix_totals[entry_count] = running_total;
          entry_count++;
        end
      end else begin
        lo = 0;
        hi = entry_count;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (prefix_totals[mid] >= value) begin
            hi = mid;
          end else begin
            lo = mid + 1;
          end
        end
        if (lo >= entry_count) begin
          ans = '{bucket: BUCKET_W'(1), not_found: 1'b1, load_dropped: 1'b0};
        end else begin
          ans = '{bucket: BUCKET_W'(lo + 1), not_found: 1'b0, load_dropped: 1'b0};
        end
        pending_answers = {pending_answers, ans};
      end
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %s: got %0h, want %0h", what, got, want);
    endtask

    task check_answer(logic [BUCKET_W-1:0] bucket, logic not_found, logic dropped);
      answer_t want;
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected beat, bucket_number", 32'(bucket), 32'h0);
      end else begin
        want = pending_answers.pop_front();
        if (bucket !== want.bucket)
          report_mismatch("bucket_number", 32'(bucket), 32'(want.bucket));
        if (not_found !== want.not_found)
          report_mismatch("not_found", 32'(not_found), 32'(want.not_found));
        if (dropped !== want.load_dropped)
          report_mismatch("load_dropped", 32'(dropped), 32'(want.load_dropped));
      end
    endtask
  endclass

  logic                clk      = 1'b0;
  logic                rst_n    = 1'b0;
  logic                start    = 1'b0;
  logic                in_mode  = MODE_APPEND;
  logic [VALUE_W-1:0]  in_value = '0;
  logic                busy;
  logic                out_valid;
  logic [BUCKET_W-1:0] out_bucket_number;
  logic                out_not_found;
  logic                out_load_dropped;

  bucket_answer_board board;
  int unsigned        cycle_count = 0;
  bit                 idle_on = 1'b1;

  prefix_sum_bucket_search dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_bucket_number (out_bucket_number),
    .out_not_found     (out_not_found),
    .out_load_dropped  (out_load_dropped)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0)
      board.check_answer(out_bucket_number, out_not_found, out_load_dropped);
  end

  task send_item(input logic mode, input logic [VALUE_W-1:0] value);
    in_mode  <= mode;
    in_value <= value;
    start    <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    board.note_item(mode, value);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task wait_for_answers();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending_answers.size() != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_size();
    logic [VALUE_W-1:0] size;
    if (board.entry_count >= DEPTH - 14) begin
      case ($urandom_range(0, 2))
        0:       size = $urandom;
        1:       size = SUM_MAX;
        default: size = $urandom_range(0, 15);
      endcase
    end else begin
      case ($urandom_range(0, 9))
        0:       size = '0;
        1:       size = 1;
        8:       size = $urandom_range(0, 1 << 21);
        9:       size = $urandom_range(0, 7);
        default: size = $urandom_range(1, 1 << 20);
      endcase
    end
    return size;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_position();
    logic [VALUE_W-1:0] pos;
    int unsigned        idx;
    if (board.entry_count == 0) return $urandom;
    idx = $urandom_range(0, board.entry_count - 1);
    case ($urandom_range(0, 9))
      0:       pos = '0;
      1, 2:    pos = board.prefix_totals[idx];
      3: begin
        pos = board.prefix_totals[idx];
        if (pos != SUM_MAX) pos = pos + 1;
      end
      4, 5:    pos = $urandom_range(0, board.running_total);
      6:       pos = board.running_total;
      7: begin
        pos = board.running_total;
        if (pos != SUM_MAX) pos = pos + 1;
      end
      8:       pos = $urandom;
      default: pos = SUM_MAX;
    endcase
    return pos;
  endfunction

  initial begin
    int unsigned i;
    bit          do_append;
    board = new;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_item(MODE_QUERY, '0);
    send_item(MODE_QUERY, SUM_MAX);
    send_item(MODE_APPEND, '0);
    send_item(MODE_QUERY, '0);
    send_item(MODE_QUERY, 1);
    send_item(MODE_APPEND, 1);
    send_item(MODE_APPEND, '0);
    send_item(MODE_QUERY, 1);
    send_item(MODE_QUERY, 2);
    send_item(MODE_APPEND, 1000);
    send_item(MODE_QUERY, 1001);
    send_item(MODE_QUERY, 1000);
    send_item(MODE_QUERY, 1002);
    send_item(MODE_QUERY, SUM_MAX);
    send_item(MODE_QUERY, 32'hAAAA_AAAA);
    send_item(MODE_QUERY, 32'h5555_5555);
    send_item(MODE_APPEND, 32'h0000_0300);
    send_item(MODE_QUERY, 32'h0000_0400);
    wait_for_answers();

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      idle_on = (i < RANDOM_ITEMS - 250) && ((i / 100) % 3 != 2);
      if (i % 250 == 249) wait_for_answers();
      if (board.entry_count < DEPTH) do_append = ($urandom_range(0, 9) < 7);
      else                           do_append = ($urandom_range(0, 9) < 3);
      if (do_append) begin
        send_item(MODE_APPEND, pick_size());
      end else begin
        send_item(MODE_QUERY, pick_position());
      end
    end

    wait_for_answers();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
